/* sv/htag_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htag_pkg
// Shared sizes, types and helpers for the hinted LRU tag store.
// ----------------------------------------------------------------------------
package htag_pkg;

    localparam int SETS        = 1024;
    localparam int WAYS        = 16;
    localparam int OFFSET_BITS = 6;

    localparam int SET_BITS  = $clog2(SETS);
    localparam int SET_IW    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W     = WAY_W;
    localparam int TAG_W     = 16;
    localparam int TAG_LO    = OFFSET_BITS + SET_BITS;
    localparam int REUSE_W   = 4;
    localparam int WAYOUT_W  = 4;
    localparam logic [REUSE_W-1:0] REUSE_MAX = 4'd15;

    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [AGE_W-1:0]   age_t;
    typedef logic [SET_IW-1:0]  set_t;
    typedef logic [WAY_W-1:0]   way_t;

    typedef struct packed {
        logic               valid;
        logic               hint;
        logic [REUSE_W-1:0] reuse;
        age_t               age;
    } meta_t;

    typedef tag_t  [WAYS-1:0] tag_row_t;
    typedef meta_t [WAYS-1:0] meta_row_t;

    typedef struct packed {
        logic                hit;
        logic [WAYOUT_W-1:0] way;
        logic                evicted;
        tag_t                evicted_tag;
        logic [REUSE_W-1:0]  evicted_reuse;
    } result_t;

    typedef struct packed {
        logic rd_en;
        set_t rd_set;
        logic wr_en;
        set_t wr_set;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Set index; an index of SETS or more wraps once.
    function automatic set_t set_of(input logic [31:0] addr);
        logic [31:0]       rest;
        logic [SET_IW:0]   raw;
        rest = addr >> OFFSET_BITS;
        raw  = (SET_BITS > 0) ? {1'b0, rest[SET_IW-1:0]} : '0;
        if (raw >= (SET_IW+1)'(SETS))
            raw = raw - (SET_IW+1)'(SETS);
        return raw[SET_IW-1:0];
    endfunction

    // Tag is the 16 bits above the set index; higher bits alias.
    function automatic tag_t tag_of(input logic [31:0] addr);
        logic [47:0] wide;
        wide = {16'b0, addr} >> TAG_LO;
        return wide[TAG_W-1:0];
    endfunction

    function automatic logic [WAYOUT_W-1:0] way_out(input way_t w);
        logic [WAY_W+WAYOUT_W-1:0] t;
        t = {{WAYOUT_W{1'b0}}, w};
        return t[WAYOUT_W-1:0];
    endfunction

    function automatic meta_row_t meta_reset_row();
        meta_row_t row;
        for (int w = 0; w < WAYS; w++)
        begin
            row[w].valid = 1'b0;
            row[w].hint  = 1'b0;
            row[w].reuse = '0;
            row[w].age   = age_t'(w);
        end
        return row;
    endfunction

endpackage
`default_nettype wire

/* sv/hinted_lru_cache_tag_store_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hinted_lru_cache_tag_store_unit
// Set-associative tag store with age LRU replacement and a liveness hint.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                      tuser
//  s_*      in   [31:0] addr                                [0] is_live
//  m_*      out  [3:0] way, [19:4] evicted_tag,             [0] hit,
//                [23:20] evicted_reuse                      [1] evicted
//
//  The set is read from the set memories on accept, then compared, updated
//  and written back in the lookup state, which holds until the output is free.
//  After reset a sweep over all SETS sets (1024) clears the metadata memory;
//  s_tready stays low until it ends.
//  A result held in the output register stalls the write-back of the next
//  item until m_tready frees it.
// ----------------------------------------------------------------------------
module hinted_lru_cache_tag_store_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] addr
    input  wire  [0:0]  s_tuser,   // [0] is_live
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [3:0] way, [19:4] evicted_tag, [23:20] evicted_reuse
    output logic [1:0]  m_tuser    // [0] hit, [1] evicted
);
    import htag_pkg::*;

    state_t    state_reg, state_next;
    mem_req_t  req;
    logic      clearing;
    logic      out_free;
    logic      commit;

    set_t      set_reg;
    tag_t      tag_reg;
    logic      live_reg;

    tag_row_t  rd_tag, new_tag;
    meta_row_t rd_meta, new_meta;
    result_t   res, res_reg;
    logic      out_valid_reg, out_valid_next;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (!clearing) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_LOOKUP;
            ST_LOOKUP: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        commit     = 1'b0;
        req.rd_en  = 1'b0;
        req.rd_set = set_of(s_tdata);
        req.wr_en  = 1'b0;
        req.wr_set = set_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                req.rd_en = s_tvalid;
            end
            ST_LOOKUP:
            begin
                commit    = out_free;
                req.wr_en = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the item while its set is read and updated.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            set_reg  <= set_of(s_tdata);
            tag_reg  <= tag_of(s_tdata);
            live_reg <= s_tuser[0];
        end
        if (commit)
            res_reg <= res;
    end

    htag_array u_array (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .wr_tag   (new_tag),
        .wr_meta  (new_meta),
        .rd_tag   (rd_tag),
        .rd_meta  (rd_meta),
        .clearing (clearing)
    );

    htag_update u_update (
        .rd_tag   (rd_tag),
        .rd_meta  (rd_meta),
        .tag      (tag_reg),
        .live     (live_reg),
        .new_tag  (new_tag),
        .new_meta (new_meta),
        .res      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.evicted_reuse, res_reg.evicted_tag, res_reg.way};
    assign m_tuser  = {res_reg.evicted, res_reg.hit};

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready)
        else $error("item accepted during clearing sweep");

    a_no_read_over_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && s_tready))
        else $error("set read overlaps a pending write-back");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (!m_tvalid || m_tready))
        else $error("write-back with result register still full");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted before write-back");
`endif

endmodule
`default_nettype wire

/* sv/htag_array.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htag_array
// Set-wide tag and metadata memories with a registered read, and a metadata
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module htag_array (
    input  wire                  clk,
    input  wire                  rst_n,
    input  htag_pkg::mem_req_t   req,
    input  htag_pkg::tag_row_t   wr_tag,
    input  htag_pkg::meta_row_t  wr_meta,
    output htag_pkg::tag_row_t   rd_tag,
    output htag_pkg::meta_row_t  rd_meta,
    output logic                 clearing
);
    import htag_pkg::*;

    tag_row_t  tag_mem  [SETS];
    meta_row_t meta_mem [SETS];

    tag_row_t  rd_tag_reg;
    meta_row_t rd_meta_reg;

    logic clear_reg, clear_next;
    set_t clr_idx_reg, clr_idx_next;

    always_comb
    begin
        clear_next   = clear_reg;
        clr_idx_next = clr_idx_reg;
        if (clear_reg)
        begin
            if (clr_idx_reg == set_t'(SETS - 1))
                clear_next = 1'b0;
            else
                clr_idx_next = clr_idx_reg + set_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // Tags are not cleared by the sweep; they are written back with every access.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            tag_mem[req.wr_set] <= wr_tag;
        if (req.rd_en)
            rd_tag_reg <= tag_mem[req.rd_set];
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
            meta_mem[clr_idx_reg] <= meta_reset_row();
        else if (req.wr_en)
            meta_mem[req.wr_set] <= wr_meta;
        if (req.rd_en)
            rd_meta_reg <= meta_mem[req.rd_set];
    end

    assign rd_tag   = rd_tag_reg;
    assign rd_meta  = rd_meta_reg;
    assign clearing = clear_reg;

endmodule
`default_nettype wire

/* sv/htag_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htag_update
// Way compare, victim choice and new set contents for one access.
// ----------------------------------------------------------------------------
module htag_update (
    input  htag_pkg::tag_row_t   rd_tag,
    input  htag_pkg::meta_row_t  rd_meta,
    input  htag_pkg::tag_t       tag,
    input  wire                  live,
    output htag_pkg::tag_row_t   new_tag,
    output htag_pkg::meta_row_t  new_meta,
    output htag_pkg::result_t    res
);
    import htag_pkg::*;

    localparam int TREE_N = 1 << WAY_W;

    logic hit_any, free_any;
    way_t hit_way, free_way, old_way, victim;
    age_t hage;

    age_t node_age [2*TREE_N];
    way_t node_idx [2*TREE_N];

    // Lowest matching way, lowest invalid or dead way.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_meta[w].valid && rd_tag[w] == tag)
            begin
                hit_any = 1'b1;
                hit_way = way_t'(w);
            end
            if (!rd_meta[w].valid || !rd_meta[w].hint)
            begin
                free_any = 1'b1;
                free_way = way_t'(w);
            end
        end
    end

    // Oldest way by tree; left side wins ties so the lowest way is kept.
    always_comb
    begin
        node_age[0] = '0;
        node_idx[0] = '0;
        for (int i = 0; i < TREE_N; i++)
        begin
            node_idx[TREE_N + i] = way_t'(i);
            if (i < WAYS)
                node_age[TREE_N + i] = rd_meta[i].age;
            else
                node_age[TREE_N + i] = '0;
        end
        for (int n = TREE_N - 1; n >= 1; n--)
        begin
            if (node_age[2*n + 1] > node_age[2*n])
            begin
                node_age[n] = node_age[2*n + 1];
                node_idx[n] = node_idx[2*n + 1];
            end
            else
            begin
                node_age[n] = node_age[2*n];
                node_idx[n] = node_idx[2*n];
            end
        end
        old_way = node_idx[1];
    end

    assign victim = free_any ? free_way : old_way;
    assign hage   = rd_meta[hit_way].age;

    always_comb
    begin
        new_tag  = rd_tag;
        new_meta = rd_meta;
        if (hit_any)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (way_t'(w) != hit_way && rd_meta[w].valid && rd_meta[w].age < hage)
                    new_meta[w].age = rd_meta[w].age + age_t'(1);
            end
            new_meta[hit_way].age  = '0;
            new_meta[hit_way].hint = live;
            if (rd_meta[hit_way].reuse != REUSE_MAX)
                new_meta[hit_way].reuse = rd_meta[hit_way].reuse + 4'd1;
        end
        else
        begin
            // Fill keeps the victim's age.
            new_tag[victim]        = tag;
            new_meta[victim].valid = 1'b1;
            new_meta[victim].hint  = live;
            new_meta[victim].reuse = '0;
        end
    end

    always_comb
    begin
        res.hit           = hit_any;
        res.way           = way_out(hit_any ? hit_way : victim);
        res.evicted       = !hit_any && rd_meta[victim].valid;
        res.evicted_tag   = res.evicted ? rd_tag[victim] : '0;
        res.evicted_reuse = res.evicted ? rd_meta[victim].reuse : '0;
    end

endmodule
`default_nettype wire

/* test/tb_hinted_lru_cache_tag_store_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hinted_lru_cache_tag_store_unit
// Checks each lookup result of the hinted LRU tag store against a predictor
// of the tag, age, hint and reuse state. Covers hits, fills of empty ways,
// evictions of dead lines, eviction of the oldest line in a set full of live
// lines, and reuse saturation. Random gaps on both stream sides, a long output
// stall and a drain pause are included.
// ----------------------------------------------------------------------------
module tb_hinted_lru_cache_tag_store_unit;
    import htag_pkg::*;

    localparam int LINE_COUNT  = SETS * WAYS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_GAP     = 16;
    localparam logic [3:0] REUSE_TOP = 4'd15;
    localparam logic [31:0] OFFSET_MAX = 32'((64'd1 << OFFSET_BITS) - 64'd1);

    typedef struct packed {
        logic        hit;
        logic [3:0]  way;
        logic        evicted;
        logic [15:0] evicted_tag;
        logic [3:0]  evicted_reuse;
    } lookup_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] addr
    logic [0:0]  s_tuser;   // [0] is_live
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [3:0] way, [19:4] evicted_tag, [23:20] evicted_reuse
    logic [1:0]  m_tuser;   // [0] hit, [1] evicted

    // Predicted tag store contents
    tag_t       line_tags  [LINE_COUNT];
    logic       line_vld   [LINE_COUNT];
    age_t       line_ages  [LINE_COUNT];
    logic       line_live  [LINE_COUNT];
    logic [3:0] line_reuse [LINE_COUNT];

    lookup_res_t pending_lookups[$];
    int          mismatch_count;
    int          cycle_count;
    bit          idle_on;
    int          hold_len;

    hinted_lru_cache_tag_store_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_store();
        for (int k = 0; k < LINE_COUNT; k++)
        begin
            line_tags[k]  = '0;
            line_vld[k]   = 1'b0;
            line_ages[k]  = age_t'(k % WAYS);
            line_live[k]  = 1'b0;
            line_reuse[k] = '0;
        end
    endfunction

    function automatic logic [31:0] line_addr(input int unsigned tag, input int unsigned set_idx,
                                              input logic [31:0] offset);
        return 32'((64'(tag) << TAG_LO) | (64'(set_idx) << OFFSET_BITS) | 64'(offset));
    endfunction

    // Look the address up in the predicted store, update it, queue the result.
    function automatic void predict_lookup(input logic [31:0] addr, input logic live);
        logic [31:0]  rest;
        int unsigned  set_idx;
        int unsigned  base;
        int           hit_way;
        int           victim;
        age_t         oldest;
        tag_t         tag;
        age_t         hit_age;
        lookup_res_t  res;
        rest    = addr >> OFFSET_BITS;
        set_idx = rest & ((32'd1 << SET_BITS) - 32'd1);
        if (set_idx >= SETS)
            set_idx = set_idx - SETS;
        tag     = tag_t'(rest >> SET_BITS);
        base    = set_idx * WAYS;
        hit_way = -1;
        res     = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit_way < 0 && line_vld[base + w] && line_tags[base + w] == tag)
                hit_way = w;
        end
        if (hit_way >= 0)
        begin
            hit_age = line_ages[base + hit_way];
            for (int w = 0; w < WAYS; w++)
            begin
                if (w != hit_way && line_vld[base + w] && line_ages[base + w] < hit_age)
                    line_ages[base + w] = line_ages[base + w] + age_t'(1);
            end
            line_ages[base + hit_way] = '0;
            line_live[base + hit_way] = live;
            if (line_reuse[base + hit_way] != REUSE_TOP)
                line_reuse[base + hit_way] = line_reuse[base + hit_way] + 4'd1;
            res.hit = 1'b1;
            res.way = 4'(hit_way);
        end
        else
        begin
            // First empty or dead way wins; otherwise the strictly oldest way.
            victim = -1;
            oldest = '0;
            for (int w = 0; w < WAYS; w++)
            begin
                if (victim < 0 && (!line_vld[base + w] || !line_live[base + w]))
                    victim = w;
            end
            if (victim < 0)
            begin
                victim = 0;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (line_ages[base + w] > oldest)
                    begin
                        oldest = line_ages[base + w];
                        victim = w;
                    end
                end
            end
            if (line_vld[base + victim])
            begin
                res.evicted       = 1'b1;
                res.evicted_tag   = line_tags[base + victim];
                res.evicted_reuse = line_reuse[base + victim];
            end
            line_tags[base + victim]  = tag;
            line_vld[base + victim]   = 1'b1;
            line_live[base + victim]  = live;
            line_reuse[base + victim] = '0;
            res.way = 4'(victim);
        end
        pending_lookups.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item; valid stays high after acceptance until the next call or a pause.
    task automatic send_access(input logic [31:0] addr, input logic live);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= live;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_lookup(addr, live);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_access_mix(input int n_items, input int n_sets, input int n_tags,
                                  input int live_pct);
        int unsigned set_pool[4];
        int unsigned tag_pool[32];
        int unsigned pick;
        logic [31:0] addr;
        for (int i = 0; i < n_sets; i++)
            set_pool[i] = $urandom_range(0, SETS - 1);
        case ($urandom_range(0, 2))
            0: set_pool[0] = 0;
            1: set_pool[0] = SETS - 1;
            default: ;
        endcase
        for (int i = 0; i < n_tags; i++)
            tag_pool[i] = $urandom_range(0, 65535);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                addr = $urandom();
            else
            begin
                // Favor two hot tags so reuse counts saturate.
                pick = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 1)
                                                    : $urandom_range(0, n_tags - 1);
                addr = line_addr(tag_pool[pick], set_pool[$urandom_range(0, n_sets - 1)],
                                 $urandom_range(0, OFFSET_MAX));
            end
            send_access(addr, $urandom_range(0, 99) < live_pct);
        end
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(line_addr(0, 0, OFFSET_MAX), 1'b1);
        send_access(line_addr(1, 0, 0), 1'b0);
        send_access(line_addr(2, 0, 0), 1'b1);
        // way 1 was refilled with a live line, so the empty way 2 goes next
        send_access(line_addr(3, 0, 0), 1'b1);
        // fill the last set with live lines, then force an age-based eviction
        for (int t = 1; t < WAYS; t++)
            send_access(line_addr(t, SETS - 1, $urandom_range(0, OFFSET_MAX)), 1'b1);
        send_access(line_addr(32'h1234, SETS - 1, 0), 1'b1);
        send_access(line_addr(32'h1234, SETS - 1, OFFSET_MAX), 1'b0);
        send_access(line_addr(32'h4321, SETS - 1, 0), 1'b1);
    endtask

    task automatic test_random_mix();
        int live_mix[7] = '{100, 95, 90, 70, 50, 20, 0};
        for (int p = 0; p < 14; p++)
        begin
            idle_on = (p % 4) != 3;
            run_access_mix(100, 1 + p % 3, 17 + p % 8, live_mix[p % 7]);
        end
    endtask

    task automatic test_output_stall();
        idle_on  = 1'b0;
        hold_len = 400;
        run_access_mix(60, 1, 20, 90);
        idle_on  = 1'b1;
    endtask

    task automatic test_drain_pause();
        idle_on = 1'b1;
        for (int c = 0; c < 10; c++)
        begin
            run_access_mix(10, 2, 18, 80);
            wait_drain();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_access_mix(150, 2, 20, 80);
    endtask

    // Output side: random ready gaps, plus a long hold when requested.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        lookup_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("unexpected result", int'({m_tuser, m_tdata}), 0);
            else
            begin
                want = pending_lookups.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", int'(m_tuser[0]), int'(want.hit));
                if (m_tdata[3:0] !== want.way)
                    report_mismatch("way", int'(m_tdata[3:0]), int'(want.way));
                if (m_tuser[1] !== want.evicted)
                    report_mismatch("evicted", int'(m_tuser[1]), int'(want.evicted));
                if (m_tdata[19:4] !== want.evicted_tag)
                    report_mismatch("evicted_tag", int'(m_tdata[19:4]),
                                    int'(want.evicted_tag));
                if (m_tdata[23:20] !== want.evicted_reuse)
                    report_mismatch("evicted_reuse", int'(m_tdata[23:20]),
                                    int'(want.evicted_reuse));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_len       = 0;
        clear_store();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix();
        test_output_stall();
        test_drain_pause();
        test_back_to_back();

        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* hinted_lru_cache_tag_store_unit.f */
sv/htag_pkg.sv
sv/htag_array.sv
sv/htag_update.sv
sv/hinted_lru_cache_tag_store_unit.sv
test/tb_hinted_lru_cache_tag_store_unit.sv
